// ----- hdl/sla_pkg.sv -----
package sla_pkg;

  localparam int NUM_ACTIONS  = 4;
  localparam int NUM_FEATURES = 32;
  localparam int TABLE_SIZE   = NUM_ACTIONS * NUM_FEATURES;

  localparam int ACT_W  = $clog2(NUM_ACTIONS);
  localparam int FEAT_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int N_W    = $clog2(NUM_FEATURES + 1);

  localparam int W_W    = 32;
  localparam int TR_W   = 17;
  localparam int CFG_W  = 16;
  localparam int REW_W  = 16;
  localparam int SEED_W = 16;
  localparam int Q_W    = 40;
  localparam int MAG_W  = 40;
  localparam int HALF_W = 20;
  localparam int ACC_W  = 64;
  localparam int DIV_W  = 42;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  localparam logic [TR_W-1:0] TRACE_ONE = TR_W'(65536);
  localparam logic [31:0] FEAT_MASK =
    (NUM_FEATURES >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << NUM_FEATURES) - 64'd1);

  localparam logic [CFG_W-1:0] STEP_RST  = 16'd6554;
  localparam logic [CFG_W-1:0] EXPL_RST  = 16'd6554;
  localparam logic [CFG_W-1:0] DECAY_RST = 16'd58982;
  localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_EXPL  = 2'd1;
  localparam logic [1:0] REG_DECAY = 2'd2;

  localparam logic [1:0] OP_LEARN  = 2'd0;
  localparam logic [1:0] OP_GREEDY = 2'd1;
  localparam logic [1:0] OP_REWARD = 2'd2;

  localparam logic [1:0] KIND_EXPLORE = 2'd0;
  localparam logic [1:0] KIND_GREEDY  = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE, S_Q_RD, S_Q_ACC, S_Q_DONE, S_DELTA,
    S_DEC_RD, S_DEC_MUL, S_DEC_WR,
    S_STEP_M0, S_STEP_M1, S_STEP_FIN,
    S_UPD_RD, S_UPD_M0, S_UPD_M1, S_UPD_DS, S_UPD_DIV, S_UPD_WR,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {QM_GREEDY, QM_CUR, QM_PREV} qmode_t;

  typedef enum logic [2:0] {MAC_NOP, MAC_CLR, MAC_ADD, MAC_MUL_LO, MAC_MUL_HI} mac_op_t;

  typedef struct packed {
    mac_op_t                  op;
    logic [HALF_W-1:0]        a;
    logic [TR_W-1:0]          b;
    logic signed [ACC_W-1:0]  addend;
  } mac_ctl_t;

  function automatic logic feat_on(input logic [31:0] mask, input logic [FEAT_W-1:0] f);
    logic [63:0] ext;
    ext = 64'(mask);
    return ext[f];
  endfunction

  function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
    logic [SEED_W-1:0] n;
    n = s >> 1;
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

// ----- hdl/sla_mac.sv -----
module sla_mac (
  input  logic                                clk,
  input  sla_pkg::mac_ctl_t                   ctl,
  output logic signed [sla_pkg::ACC_W-1:0]    acc
);

  logic [sla_pkg::HALF_W+sla_pkg::TR_W-1:0] prod;
  logic [sla_pkg::ACC_W-1:0]                prod_ext;
  logic signed [sla_pkg::ACC_W-1:0]         acc_r;

  assign prod     = ctl.a * ctl.b;
  assign prod_ext = sla_pkg::ACC_W'(prod);
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    case (ctl.op)
      sla_pkg::MAC_CLR:    acc_r <= '0;
      sla_pkg::MAC_ADD:    acc_r <= acc_r + ctl.addend;
      sla_pkg::MAC_MUL_LO: acc_r <= $signed(prod_ext);
      sla_pkg::MAC_MUL_HI: acc_r <= acc_r + $signed(prod_ext << sla_pkg::HALF_W);
      default:             acc_r <= acc_r;
    endcase
  end

endmodule

// ----- hdl/sla_div.sv -----
module sla_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sla_pkg::DIV_W-1:0]   dividend,
  input  logic [sla_pkg::N_W-1:0]     divisor,
  output logic                        done,
  output logic [sla_pkg::DIV_W-1:0]   quot
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [sla_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sla_pkg::DIV_W-1:0]   quot_r, quot_nxt;
  logic [sla_pkg::N_W-1:0]     rem_r, rem_nxt;
  logic [sla_pkg::N_W-1:0]     dvs_r, dvs_nxt;
  logic [sla_pkg::N_W:0]       trial;

  assign done = done_r;
  assign quot = quot_r;
  assign trial = {rem_r, quot_r[sla_pkg::DIV_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = sla_pkg::N_W'(trial - {1'b0, dvs_r});
        quot_nxt = {quot_r[sla_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt  = sla_pkg::N_W'(trial);
        quot_nxt = {quot_r[sla_pkg::DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == sla_pkg::CNT_W'(sla_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

endmodule

// ----- hdl/sarsa_lambda_linear_agent_top.sv -----
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/tready   | tuser opcode, tlast episode end, tdata features etc.
// out     | out | out_tvalid/tready  | tuser choice kind, tdata action and skip flag
// cfg     | in  | psel/penable       | three 16-bit registers at 0x0, 0x4, 0x8
// One item at a time; one shared multiply-accumulate unit and a serial divider.
// Each Q sum visits every feature and accumulates the weight of each active feature.
// Learning step: greedy sums unless exploring; after a prior learning step, two sums
// (current, previous), decay pass over the table, update pass (divider per nonzero trace).
// Reset clears all tables through valid bits at once; no clearing pass.
// A finished result waits in the output register while the next item runs.
module sarsa_lambda_linear_agent_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] feature_mask, [47:32] reward_value, [63:48] explore_draw,
  // [65:64] random_action, [81:66] tie_seed, [87:82] zero
  input  logic [87:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] chosen_action, [2] update_skipped, [7:3] zero
  output logic [7:0]  out_tdata,
  // [1:0] choice_kind
  output logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int ACT_W  = sla_pkg::ACT_W;
  localparam int FEAT_W = sla_pkg::FEAT_W;
  localparam int IDX_W  = sla_pkg::IDX_W;
  localparam int DL_W   = sla_pkg::Q_W + 2;
  localparam int SUM_W  = sla_pkg::DIV_W + 2;

  // configuration
  logic [15:0] step_r, expl_r, decay_r;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    case (cfg_idx)
      sla_pkg::REG_STEP:  cfg_prdata = 32'(step_r);
      sla_pkg::REG_EXPL:  cfg_prdata = 32'(expl_r);
      sla_pkg::REG_DECAY: cfg_prdata = 32'(decay_r);
      default:            cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= sla_pkg::STEP_RST;
      expl_r  <= sla_pkg::EXPL_RST;
      decay_r <= sla_pkg::DECAY_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == sla_pkg::REG_STEP)  step_r  <= cfg_pwdata[15:0];
      if (cfg_idx == sla_pkg::REG_EXPL)  expl_r  <= cfg_pwdata[15:0];
      if (cfg_idx == sla_pkg::REG_DECAY) decay_r <= cfg_pwdata[15:0];
    end
  end

  // input fields
  logic [31:0] in_mask;
  logic [15:0] in_rew, in_draw, in_seed;
  logic [1:0]  in_ract;

  assign in_mask = in_tdata[31:0];
  assign in_rew  = in_tdata[47:32];
  assign in_draw = in_tdata[63:48];
  assign in_ract = in_tdata[65:64];
  assign in_seed = in_tdata[81:66];

  // state
  sla_pkg::state_t state_r, state_nxt;
  sla_pkg::qmode_t qmode_r, qmode_nxt;
  logic [1:0]              op_r, op_nxt;
  logic [31:0]             mask_r, mask_nxt;
  logic signed [15:0]      rew_r, rew_nxt;
  logic                    end_r, end_nxt;
  logic [15:0]             lfsr_r, lfsr_nxt;
  logic [ACT_W-1:0]        act_r, act_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic                    skip_r, skip_nxt;
  logic [ACT_W-1:0]        gact_r, gact_nxt;
  logic [ACT_W-1:0]        best_r, best_nxt;
  logic signed [sla_pkg::Q_W-1:0] bestv_r, bestv_nxt;
  logic [ACT_W:0]          ties_r, ties_nxt;
  logic [ACT_W-1:0]        a_cnt_r, a_cnt_nxt;
  logic [FEAT_W-1:0]       f_cnt_r, f_cnt_nxt;
  logic signed [sla_pkg::Q_W-1:0] qcur_r, qcur_nxt, qprev_r, qprev_nxt;
  logic                    dsign_r, dsign_nxt;
  logic [sla_pkg::MAG_W-1:0] dmag_r, dmag_nxt, stepmag_r, stepmag_nxt;
  logic [sla_pkg::N_W-1:0] n_r, n_nxt;
  logic                    zero_r, zero_nxt;
  logic [31:0]             prev_feat_r, prev_feat_nxt;
  logic [ACT_W-1:0]        prev_act_r, prev_act_nxt;
  logic                    prev_vld_r, prev_vld_nxt;
  logic signed [15:0]      srew_r, srew_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [ACT_W-1:0]        out_act_r, out_act_nxt;
  logic [1:0]              out_kind_r, out_kind_nxt;
  logic                    out_skip_r, out_skip_nxt;

  // memories
  logic [sla_pkg::W_W-1:0]  wmem [sla_pkg::TABLE_SIZE];
  logic [sla_pkg::TR_W-1:0] tmem [sla_pkg::TABLE_SIZE];
  logic [sla_pkg::TABLE_SIZE-1:0] wvld_r, tvld_r;
  logic [sla_pkg::W_W-1:0]  w_rd_r, w_wd;
  logic [sla_pkg::TR_W-1:0] t_rd_r, t_wd;
  logic                     wv_rd_r, tv_rd_r, w_we, t_we, tvld_clr;
  logic [IDX_W-1:0]         idx;
  logic signed [sla_pkg::W_W-1:0] w_val;
  logic [sla_pkg::TR_W-1:0] t_val;

  assign idx   = IDX_W'(32'(a_cnt_r) * sla_pkg::NUM_FEATURES + 32'(f_cnt_r));
  assign w_val = wv_rd_r ? $signed(w_rd_r) : '0;
  assign t_val = tv_rd_r ? t_rd_r : '0;

  always_ff @(posedge clk) begin
    if (w_we) wmem[idx] <= w_wd;
    if (t_we) tmem[idx] <= t_wd;
    w_rd_r  <= wmem[idx];
    t_rd_r  <= tmem[idx];
    wv_rd_r <= wvld_r[idx];
    tv_rd_r <= tvld_r[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= '0;
      tvld_r <= '0;
    end else begin
      if (w_we) wvld_r[idx] <= 1'b1;
      if (tvld_clr) begin
        tvld_r <= '0;
      end else if (t_we) begin
        tvld_r[idx] <= 1'b1;
      end
    end
  end

  // shared units
  sla_pkg::mac_ctl_t             mac_ctl;
  logic signed [sla_pkg::ACC_W-1:0] acc;
  logic [sla_pkg::ACC_W-1:0]     acc_u;
  logic                          div_start, div_done;
  logic [sla_pkg::DIV_W-1:0]     div_dvd, div_q;

  assign acc_u = acc;

  sla_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .acc (acc)
  );

  sla_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (n_r),
    .done     (div_done),
    .quot     (div_q)
  );

  // helpers
  logic                    last_f, last_a;
  logic [31:0]             qmask;
  logic signed [sla_pkg::Q_W-1:0] qv;
  logic [ACT_W-1:0]        ract_mod;
  logic [ACT_W-1:0]        g_best;
  logic signed [sla_pkg::Q_W-1:0] g_bestv;
  logic [ACT_W:0]          g_ties;
  logic [15:0]             g_lfsr;
  logic [16+ACT_W+1:0]     g_prod;
  logic signed [DL_W-1:0]  dl_c, rterm;
  logic [sla_pkg::ACC_W-1:0] rnd_c, tnum_c;
  logic signed [SUM_W-1:0] wsum, dsig;
  logic                    set_one;

  assign last_f = f_cnt_r == FEAT_W'(sla_pkg::NUM_FEATURES - 1);
  assign last_a = a_cnt_r == ACT_W'(sla_pkg::NUM_ACTIONS - 1);
  assign qmask  = (qmode_r == sla_pkg::QM_PREV) ? prev_feat_r : mask_r;
  assign qv     = sla_pkg::Q_W'(acc);
  assign ract_mod = (32'(in_ract) >= sla_pkg::NUM_ACTIONS) ?
                    ACT_W'(32'(in_ract) - sla_pkg::NUM_ACTIONS) : ACT_W'(in_ract);
  assign set_one = (a_cnt_r == prev_act_r) && sla_pkg::feat_on(prev_feat_r, f_cnt_r);

  always_comb begin
    g_best  = best_r;
    g_bestv = bestv_r;
    g_ties  = ties_r;
    g_lfsr  = lfsr_r;
    g_prod  = '0;
    if (gact_r == '0) begin
      g_best  = '0;
      g_bestv = qv;
      g_ties  = '0;
    end else if (qv == bestv_r) begin
      g_ties = ties_r + 1'b1;
      g_lfsr = sla_pkg::lfsr_step(lfsr_r);
      g_prod = (16+ACT_W+2)'(g_lfsr) * (16+ACT_W+2)'(g_ties + 1'b1);
      if (g_prod < (16+ACT_W+2)'(65536)) g_best = gact_r;
    end else if (qv > bestv_r) begin
      g_best  = gact_r;
      g_bestv = qv;
      g_ties  = '0;
    end
  end

  always_comb begin
    rterm = (op_r == sla_pkg::OP_LEARN) ? (DL_W'(srew_r) <<< 8) : (DL_W'(rew_r) <<< 8);
    dl_c  = rterm - DL_W'(qprev_r);
    if (op_r == sla_pkg::OP_LEARN) dl_c = dl_c + DL_W'(qcur_r);
    rnd_c  = acc_u + sla_pkg::ACC_W'(32768);
    tnum_c = (acc_u + (sla_pkg::ACC_W'(n_r) << 15)) >> 16;
    dsig   = zero_r ? '0 : (dsign_r ? -$signed(SUM_W'(div_q)) : $signed(SUM_W'(div_q)));
    wsum   = SUM_W'(w_val) + dsig;
  end

  assign div_dvd = sla_pkg::DIV_W'(tnum_c);

  always_comb begin
    state_nxt = state_r;   qmode_nxt = qmode_r;   op_nxt = op_r;
    mask_nxt = mask_r;     rew_nxt = rew_r;       end_nxt = end_r;
    lfsr_nxt = lfsr_r;     act_nxt = act_r;       kind_nxt = kind_r;
    skip_nxt = skip_r;     gact_nxt = gact_r;     best_nxt = best_r;
    bestv_nxt = bestv_r;   ties_nxt = ties_r;     a_cnt_nxt = a_cnt_r;
    f_cnt_nxt = f_cnt_r;   qcur_nxt = qcur_r;     qprev_nxt = qprev_r;
    dsign_nxt = dsign_r;   dmag_nxt = dmag_r;     stepmag_nxt = stepmag_r;
    n_nxt = n_r;           zero_nxt = zero_r;     prev_feat_nxt = prev_feat_r;
    prev_act_nxt = prev_act_r; prev_vld_nxt = prev_vld_r; srew_nxt = srew_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_act_nxt = out_act_r; out_kind_nxt = out_kind_r; out_skip_nxt = out_skip_r;
    mac_ctl = '{op: sla_pkg::MAC_NOP, a: '0, b: '0, addend: '0};
    div_start = 1'b0;
    w_we = 1'b0;  t_we = 1'b0;  tvld_clr = 1'b0;
    w_wd = '0;    t_wd = '0;

    case (state_r)
      sla_pkg::S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          mask_nxt = in_mask;
          rew_nxt  = $signed(in_rew);
          end_nxt  = in_tlast;
          lfsr_nxt = (in_seed == '0) ? 16'd1 : in_seed;
          act_nxt  = '0;
          kind_nxt = sla_pkg::KIND_NONE;
          skip_nxt = 1'b0;
          f_cnt_nxt = '0;
          state_nxt = sla_pkg::S_FIN;
          case (in_tuser)
            sla_pkg::OP_LEARN, sla_pkg::OP_GREEDY: begin
              if (in_tuser == sla_pkg::OP_LEARN && in_draw < expl_r) begin
                act_nxt  = ract_mod;
                kind_nxt = sla_pkg::KIND_EXPLORE;
                if (prev_vld_r) begin
                  qmode_nxt = sla_pkg::QM_CUR;
                  a_cnt_nxt = ract_mod;
                  mac_ctl.op = sla_pkg::MAC_CLR;
                  state_nxt = sla_pkg::S_Q_RD;
                end
              end else begin
                kind_nxt  = sla_pkg::KIND_GREEDY;
                qmode_nxt = sla_pkg::QM_GREEDY;
                gact_nxt  = '0;
                a_cnt_nxt = '0;
                mac_ctl.op = sla_pkg::MAC_CLR;
                state_nxt = sla_pkg::S_Q_RD;
              end
            end
            sla_pkg::OP_REWARD: begin
              srew_nxt = $signed(in_rew);
              if (in_tlast && prev_vld_r) begin
                qmode_nxt = sla_pkg::QM_PREV;
                a_cnt_nxt = prev_act_r;
                mac_ctl.op = sla_pkg::MAC_CLR;
                state_nxt = sla_pkg::S_Q_RD;
              end
            end
            default: state_nxt = sla_pkg::S_FIN;
          endcase
        end
      end
      sla_pkg::S_Q_RD: begin
        if (sla_pkg::feat_on(qmask, f_cnt_r)) begin
          state_nxt = sla_pkg::S_Q_ACC;
        end else if (last_f) begin
          state_nxt = sla_pkg::S_Q_DONE;
        end else begin
          f_cnt_nxt = f_cnt_r + 1'b1;
        end
      end
      sla_pkg::S_Q_ACC: begin
        mac_ctl.op = sla_pkg::MAC_ADD;
        mac_ctl.addend = sla_pkg::ACC_W'(w_val);
        if (last_f) begin
          state_nxt = sla_pkg::S_Q_DONE;
        end else begin
          f_cnt_nxt = f_cnt_r + 1'b1;
          state_nxt = sla_pkg::S_Q_RD;
        end
      end
      sla_pkg::S_Q_DONE: begin
        f_cnt_nxt = '0;
        mac_ctl.op = sla_pkg::MAC_CLR;
        state_nxt = sla_pkg::S_Q_RD;
        case (qmode_r)
          sla_pkg::QM_GREEDY: begin
            best_nxt  = g_best;
            bestv_nxt = g_bestv;
            ties_nxt  = g_ties;
            lfsr_nxt  = g_lfsr;
            if (gact_r == ACT_W'(sla_pkg::NUM_ACTIONS - 1)) begin
              act_nxt = g_best;
              if (op_r == sla_pkg::OP_LEARN && prev_vld_r) begin
                qmode_nxt = sla_pkg::QM_CUR;
                a_cnt_nxt = g_best;
              end else begin
                state_nxt = sla_pkg::S_FIN;
              end
            end else begin
              gact_nxt  = gact_r + 1'b1;
              a_cnt_nxt = gact_r + 1'b1;
            end
          end
          sla_pkg::QM_CUR: begin
            qcur_nxt  = qv;
            qmode_nxt = sla_pkg::QM_PREV;
            a_cnt_nxt = prev_act_r;
          end
          default: begin
            qprev_nxt = qv;
            mac_ctl.op = sla_pkg::MAC_NOP;
            state_nxt = sla_pkg::S_DELTA;
          end
        endcase
      end
      sla_pkg::S_DELTA: begin
        dsign_nxt = dl_c < 0;
        dmag_nxt  = sla_pkg::MAG_W'((dl_c < 0) ? -dl_c : dl_c);
        n_nxt     = sla_pkg::N_W'($countones(prev_feat_r & sla_pkg::FEAT_MASK));
        a_cnt_nxt = '0;
        f_cnt_nxt = '0;
        state_nxt = sla_pkg::S_DEC_RD;
      end
      sla_pkg::S_DEC_RD: state_nxt = sla_pkg::S_DEC_MUL;
      sla_pkg::S_DEC_MUL: begin
        mac_ctl.op = sla_pkg::MAC_MUL_LO;
        mac_ctl.a  = sla_pkg::HALF_W'(t_val);
        mac_ctl.b  = sla_pkg::TR_W'(decay_r);
        state_nxt  = sla_pkg::S_DEC_WR;
      end
      sla_pkg::S_DEC_WR: begin
        t_we = 1'b1;
        t_wd = set_one ? sla_pkg::TRACE_ONE : acc_u[16 +: sla_pkg::TR_W];
        state_nxt = sla_pkg::S_DEC_RD;
        if (last_f) begin
          f_cnt_nxt = '0;
          if (last_a) begin
            a_cnt_nxt = '0;
            if (n_r == '0) begin
              skip_nxt  = 1'b1;
              state_nxt = sla_pkg::S_FIN;
            end else begin
              state_nxt = sla_pkg::S_STEP_M0;
            end
          end else begin
            a_cnt_nxt = a_cnt_r + 1'b1;
          end
        end else begin
          f_cnt_nxt = f_cnt_r + 1'b1;
        end
      end
      sla_pkg::S_STEP_M0: begin
        mac_ctl.op = sla_pkg::MAC_MUL_LO;
        mac_ctl.a  = dmag_r[sla_pkg::HALF_W-1:0];
        mac_ctl.b  = sla_pkg::TR_W'(step_r);
        state_nxt  = sla_pkg::S_STEP_M1;
      end
      sla_pkg::S_STEP_M1: begin
        mac_ctl.op = sla_pkg::MAC_MUL_HI;
        mac_ctl.a  = dmag_r[sla_pkg::MAG_W-1:sla_pkg::HALF_W];
        mac_ctl.b  = sla_pkg::TR_W'(step_r);
        state_nxt  = sla_pkg::S_STEP_FIN;
      end
      sla_pkg::S_STEP_FIN: begin
        stepmag_nxt = rnd_c[16 +: sla_pkg::MAG_W];
        state_nxt   = sla_pkg::S_UPD_RD;
      end
      sla_pkg::S_UPD_RD: state_nxt = sla_pkg::S_UPD_M0;
      sla_pkg::S_UPD_M0: begin
        if (t_val == '0) begin
          zero_nxt  = 1'b1;
          state_nxt = sla_pkg::S_UPD_WR;
        end else begin
          zero_nxt   = 1'b0;
          mac_ctl.op = sla_pkg::MAC_MUL_LO;
          mac_ctl.a  = stepmag_r[sla_pkg::HALF_W-1:0];
          mac_ctl.b  = t_val;
          state_nxt  = sla_pkg::S_UPD_M1;
        end
      end
      sla_pkg::S_UPD_M1: begin
        mac_ctl.op = sla_pkg::MAC_MUL_HI;
        mac_ctl.a  = stepmag_r[sla_pkg::MAG_W-1:sla_pkg::HALF_W];
        mac_ctl.b  = t_val;
        state_nxt  = sla_pkg::S_UPD_DS;
      end
      sla_pkg::S_UPD_DS: begin
        div_start = 1'b1;
        state_nxt = sla_pkg::S_UPD_DIV;
      end
      sla_pkg::S_UPD_DIV: begin
        if (div_done) state_nxt = sla_pkg::S_UPD_WR;
      end
      sla_pkg::S_UPD_WR: begin
        w_we = 1'b1;
        if (wsum > SUM_W'(32'sh7FFF_FFFF)) begin
          w_wd = 32'h7FFF_FFFF;
        end else if (wsum < -SUM_W'(33'sh0_8000_0000)) begin
          w_wd = 32'h8000_0000;
        end else begin
          w_wd = sla_pkg::W_W'(wsum);
        end
        state_nxt = sla_pkg::S_UPD_RD;
        if (last_f) begin
          f_cnt_nxt = '0;
          if (last_a) begin
            a_cnt_nxt = '0;
            state_nxt = sla_pkg::S_FIN;
          end else begin
            a_cnt_nxt = a_cnt_r + 1'b1;
          end
        end else begin
          f_cnt_nxt = f_cnt_r + 1'b1;
        end
      end
      sla_pkg::S_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_act_nxt   = act_r;
          out_kind_nxt  = kind_r;
          out_skip_nxt  = skip_r;
          if (op_r == sla_pkg::OP_LEARN) begin
            prev_feat_nxt = mask_r;
            prev_act_nxt  = act_r;
            prev_vld_nxt  = 1'b1;
          end else if (op_r == sla_pkg::OP_REWARD && end_r) begin
            tvld_clr     = 1'b1;
            prev_vld_nxt = 1'b0;
          end
          state_nxt = sla_pkg::S_IDLE;
        end
      end
      default: state_nxt = sla_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sla_pkg::S_IDLE;
      prev_feat_r <= '0;
      prev_act_r  <= '0;
      prev_vld_r  <= 1'b0;
      srew_r      <= '0;
      lfsr_r      <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_feat_r <= prev_feat_nxt;
      prev_act_r  <= prev_act_nxt;
      prev_vld_r  <= prev_vld_nxt;
      srew_r      <= srew_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    qmode_r <= qmode_nxt;   op_r <= op_nxt;       mask_r <= mask_nxt;
    rew_r <= rew_nxt;       end_r <= end_nxt;     act_r <= act_nxt;
    kind_r <= kind_nxt;     skip_r <= skip_nxt;   gact_r <= gact_nxt;
    best_r <= best_nxt;     bestv_r <= bestv_nxt; ties_r <= ties_nxt;
    a_cnt_r <= a_cnt_nxt;   f_cnt_r <= f_cnt_nxt; qcur_r <= qcur_nxt;
    qprev_r <= qprev_nxt;   dsign_r <= dsign_nxt; dmag_r <= dmag_nxt;
    stepmag_r <= stepmag_nxt; n_r <= n_nxt;       zero_r <= zero_nxt;
    out_act_r <= out_act_nxt; out_kind_r <= out_kind_nxt; out_skip_r <= out_skip_nxt;
  end

  assign in_tready  = state_r == sla_pkg::S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_skip_r, 2'(out_act_r)};
  assign out_tuser  = out_kind_r;

`ifndef SYNTH
  a_upd_needs_feat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sla_pkg::S_UPD_WR) |-> (n_r != '0))
    else $error("weight update with no active feature");
  a_mul_hi_order: assert property (@(posedge clk) disable iff (!rst_n)
    (mac_ctl.op == sla_pkg::MAC_MUL_HI) |-> ($past(mac_ctl.op) == sla_pkg::MAC_MUL_LO))
    else $error("high partial product without low one");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != sla_pkg::S_IDLE))
    else $error("accepted item left block idle");
`endif

endmodule
